// ----- rtl/rcch_pkg.sv -----
// Shared types, constants and elaboration-time tables for the grid ray caster.
// Used by every module of the block; depends on nothing.
`default_nettype none
package rcch_pkg;

  localparam int SCREEN_COLUMNS = 120;
  localparam int SCREEN_ROWS    = 40;
  localparam int MAP_SIZE       = 16;
  localparam int MAX_STEPS      = 160;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  localparam logic [9:0] HALF_FOV   = 10'd64;
  localparam logic [9:0] QUARTER    = 10'd256;

  localparam int CFG_MAP0  = 0;
  localparam int CFG_MAP1  = 1;
  localparam int CFG_MAP2  = 2;
  localparam int CFG_MAP3  = 3;
  localparam int CFG_VX    = 4;
  localparam int CFG_VY    = 5;
  localparam int CFG_ANGLE = 6;

  typedef struct packed {
    logic [6:0]         column;
    logic signed [13:0] dx;
    logic signed [13:0] dy;
  } ray_entry_t;

  typedef struct packed {
    logic [6:0] column;
    logic [5:0] first_row;
    logic [5:0] end_row;
    logic [7:0] steps;
    logic       hit;
  } ray_result_t;

  typedef enum logic [1:0] {
    MS_IDLE,
    MS_RUN,
    MS_DONE
  } march_state_t;

  typedef logic [12:0] inc_lut_t [0:256];
  typedef logic [7:0]  col_lut_t [0:127];
  typedef logic [11:0] row_lut_t [0:255];

  // Per-step increment magnitude (Q16 cell units): one tenth of sin(k*pi/512).
  function automatic inc_lut_t build_inc_lut();
    inc_lut_t    t;
    logic [63:0] x;
    logic [63:0] term;
    logic signed [64:0] sum;
    logic [63:0] q14;
    logic [63:0] prod;
    for (int k = 0; k <= 256; k++) begin
      x = (64'(k) * PI_Q30) >> 9;
      term = x;
      sum = 65'(x);
      for (int n = 1; n <= 7; n++) begin
        term = (term * x) >> 30;
        prod = (term * x) >> 30;
        case (n)
          1: term = prod / 64'd6;
          2: term = prod / 64'd20;
          3: term = prod / 64'd42;
          4: term = prod / 64'd72;
          5: term = prod / 64'd110;
          6: term = prod / 64'd156;
          default: term = prod / 64'd210;
        endcase
        if (n % 2 == 1) begin
          sum = sum - 65'(term);
        end else begin
          sum = sum + 65'(term);
        end
      end
      if (sum < 0) sum = 0;
      if (sum > (65'sd1 <<< 30)) sum = 65'sd1 <<< 30;
      q14 = ((64'(sum) * 64'd16384) + (64'd1 << 29)) >> 30;
      t[k] = 13'((2 * q14 + 2) / 5);
    end
    return t;
  endfunction

  function automatic col_lut_t build_col_lut();
    col_lut_t t;
    for (int c = 0; c < 128; c++) begin
      t[c] = 8'((c * 128) / SCREEN_COLUMNS);
    end
    return t;
  endfunction

  // Wall rows per step count: {first_row, end_row}.
  function automatic row_lut_t build_row_lut();
    row_lut_t t;
    int num, mag, q, c, f, e;
    for (int s = 0; s < 256; s++) begin
      if (s == 0) begin
        t[s] = 12'd0;
      end else begin
        num = SCREEN_ROWS * (s - 20);
        mag = (num < 0) ? -num : num;
        q = 0;
        while (mag >= 2 * s) begin
          mag = mag - 2 * s;
          q = q + 1;
        end
        c = (num < 0) ? -q : q;
        f = c + 1;
        if (f < 0) f = 0;
        if (f > SCREEN_ROWS) f = SCREEN_ROWS;
        e = SCREEN_ROWS - c;
        if (e < 0) e = 0;
        if (e > SCREEN_ROWS) e = SCREEN_ROWS;
        if (e < f) e = f;
        t[s] = {6'(f), 6'(e)};
      end
    end
    return t;
  endfunction

  localparam inc_lut_t INC_LUT = build_inc_lut();
  localparam col_lut_t COL_LUT = build_col_lut();
  localparam row_lut_t ROW_LUT = build_row_lut();

endpackage
`default_nettype wire

// ----- rtl/grid_raycast_column_height.sv -----
// Grid ray caster top level: configuration registers, front end, queue and marcher.
// Depends on rcch_pkg, rcch_front, rcch_queue and rcch_march.
//
// Each accepted column is turned into a ray combinationally and queued (two entries).
// The marcher then advances the ray one tenth of a cell per cycle for 1 to 160 march
// steps, holds the result until it is taken and only then loads the next ray.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must
// write it only while idle, as the block itself does not enforce this.
`default_nettype none
module grid_raycast_column_height (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [6:0] column
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [6:0] column_out, [12:7] wall_first_row,
                                      // [18:13] wall_end_row, [26:19] march_steps,
                                      // [27] wall_hit
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic [63:0] map0, map1, map2, map3;
  logic [11:0] viewer_x;
  logic [11:0] viewer_y;
  logic [9:0]  view_angle;

  logic                  q_push, q_pop, q_full, q_valid;
  rcch_pkg::ray_entry_t  push_entry, head;
  rcch_pkg::ray_result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      map0       <= 64'd0;
      map1       <= 64'd0;
      map2       <= 64'd0;
      map3       <= 64'd0;
      viewer_x   <= 12'd2048;
      viewer_y   <= 12'd2048;
      view_angle <= 10'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        3'(rcch_pkg::CFG_MAP0):  map0 <= cfg_data;
        3'(rcch_pkg::CFG_MAP1):  map1 <= cfg_data;
        3'(rcch_pkg::CFG_MAP2):  map2 <= cfg_data;
        3'(rcch_pkg::CFG_MAP3):  map3 <= cfg_data;
        3'(rcch_pkg::CFG_VX):    viewer_x <= cfg_data[11:0];
        3'(rcch_pkg::CFG_VY):    viewer_y <= cfg_data[11:0];
        3'(rcch_pkg::CFG_ANGLE): view_angle <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  rcch_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .view_angle (view_angle),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (push_entry)
  );

  rcch_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_valid),
    .head       (head)
  );

  rcch_march u_march (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_entry   (head),
    .map_bits  ({map3, map2, map1, map0}),
    .viewer_x  (viewer_x),
    .viewer_y  (viewer_y),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .result    (result)
  );

  assign m_tdata = {4'd0, result.hit, result.steps, result.end_row,
                    result.first_row, result.column};

  a_steps_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (result.steps != 8'd0 && result.steps <= 8'(rcch_pkg::MAX_STEPS)))
    else $error("march step count out of range");

  a_rows_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (result.first_row <= result.end_row &&
                  result.end_row <= 6'(rcch_pkg::SCREEN_ROWS)))
    else $error("wall rows out of order");

  a_miss_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !result.hit) |-> (result.steps == 8'(rcch_pkg::MAX_STEPS)))
    else $error("ray stopped early without a wall");

endmodule
`default_nettype wire

// ----- rtl/rcch_front.sv -----
// Front end: accepts a column and turns it into the ray's per-step increments.
// Depends on rcch_pkg.
`default_nettype none
module rcch_front (
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [7:0]           s_tdata,   // [6:0] column
  input  wire logic [9:0]           view_angle,
  input  wire logic                 q_full,
  output logic                      q_push,
  output rcch_pkg::ray_entry_t      q_entry
);

  logic [6:0] column;
  logic [9:0] ray;
  logic [9:0] ray_y;

  function automatic logic signed [13:0] step_of(input logic [9:0] a);
    logic [8:0]  r;
    logic [12:0] m;
    r = {1'b0, a[7:0]};
    if (a[8]) begin
      m = rcch_pkg::INC_LUT[9'd256 - r];
    end else begin
      m = rcch_pkg::INC_LUT[r];
    end
    return a[9] ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  assign column = s_tdata[6:0];
  assign ray    = view_angle - rcch_pkg::HALF_FOV + {2'b00, rcch_pkg::COL_LUT[column]};
  assign ray_y  = ray + rcch_pkg::QUARTER;

  assign s_tready       = !q_full;
  assign q_push         = s_tvalid && !q_full;
  assign q_entry.column = column;
  assign q_entry.dx     = step_of(ray);
  assign q_entry.dy     = step_of(ray_y);

endmodule
`default_nettype wire

// ----- rtl/rcch_queue.sv -----
// Two-entry queue of prepared rays between the front end and the marcher.
// Depends on rcch_pkg.
`default_nettype none
module rcch_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire rcch_pkg::ray_entry_t push_entry,
  input  wire logic                 pop,
  output logic                      full,
  output logic                      not_empty,
  output rcch_pkg::ray_entry_t      head
);

  rcch_pkg::ray_entry_t slots [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign head      = slots[rd_ptr];

endmodule
`default_nettype wire

// ----- rtl/rcch_march.sv -----
// Back end: marches one ray a step per cycle over the wall bitmap and holds the result.
// Depends on rcch_pkg.
`default_nettype none
module rcch_march (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  output logic                      q_pop,
  input  wire rcch_pkg::ray_entry_t q_entry,
  input  wire logic [255:0]         map_bits,
  input  wire logic [11:0]          viewer_x,
  input  wire logic [11:0]          viewer_y,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output rcch_pkg::ray_result_t     result
);

  rcch_pkg::march_state_t state, state_next;
  logic [6:0]         column;
  logic signed [13:0] dx;
  logic signed [13:0] dy;
  logic signed [23:0] px;
  logic signed [23:0] py;
  logic [7:0]         steps;
  logic               hit;

  logic signed [23:0] px_next;
  logic signed [23:0] py_next;
  logic [7:0]         steps_next;
  logic               escaped;
  logic               wall;
  logic               finish;
  logic [11:0]        rows;

  assign px_next    = px + {{10{dx[13]}}, dx};
  assign py_next    = py + {{10{dy[13]}}, dy};
  assign steps_next = steps + 8'd1;
  assign escaped    = px_next[23] || py_next[23] ||
                      (px_next[22:20] != 3'd0) || (py_next[22:20] != 3'd0);
  assign wall       = map_bits[{py_next[19:16], px_next[19:16]}];
  assign finish     = escaped || wall || (steps_next == 8'(rcch_pkg::MAX_STEPS));

  always_comb begin
    state_next = state;
    unique case (state)
      rcch_pkg::MS_IDLE: if (q_valid) state_next = rcch_pkg::MS_RUN;
      rcch_pkg::MS_RUN:  if (finish) state_next = rcch_pkg::MS_DONE;
      rcch_pkg::MS_DONE: if (res_ready) state_next = rcch_pkg::MS_IDLE;
      default:           state_next = rcch_pkg::MS_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    res_valid = 1'b0;
    unique case (state)
      rcch_pkg::MS_IDLE: q_pop = q_valid;
      rcch_pkg::MS_RUN:  ;
      rcch_pkg::MS_DONE: res_valid = 1'b1;
      default:           ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcch_pkg::MS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rcch_pkg::MS_IDLE && q_valid) begin
      column <= q_entry.column;
      dx     <= q_entry.dx;
      dy     <= q_entry.dy;
      px     <= {4'd0, viewer_x, 8'd0};
      py     <= {4'd0, viewer_y, 8'd0};
      steps  <= 8'd0;
      hit    <= 1'b0;
    end else if (state == rcch_pkg::MS_RUN) begin
      px <= px_next;
      py <= py_next;
      if (escaped) begin
        steps <= 8'(rcch_pkg::MAX_STEPS);
      end else begin
        steps <= steps_next;
        hit   <= wall;
      end
    end
  end

  assign rows             = rcch_pkg::ROW_LUT[steps];
  assign result.column    = column;
  assign result.first_row = rows[11:6];
  assign result.end_row   = rows[5:0];
  assign result.steps     = steps;
  assign result.hit       = hit;

endmodule
`default_nettype wire
